// ===== src/tccw_pkg.sv =====
`default_nettype none

package tccw_pkg;

   localparam int MAX_ROWS    = 32;
   localparam int MAX_COLUMNS = 128;
   localparam int ROW_W       = $clog2(MAX_ROWS);
   localparam int COL_W       = $clog2(MAX_COLUMNS);
   localparam int ADDR_W      = ROW_W + COL_W;
   localparam int CHAR_W      = 16;
   localparam int OP_W        = 2;
   localparam int VIS_CFG_W   = 7;
   localparam int ROWS_CFG_W  = 6;
   localparam int CSR_DATA_W  = 7;

   localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
   localparam logic [OP_W-1:0] OP_READ  = 2'd2;

   localparam logic [CHAR_W-1:0] NEWLINE_CODE = 16'd10;
   localparam logic [CHAR_W-1:0] NULL_CODE    = 16'd0;

   localparam logic CSR_VISIBLE_COLUMNS = 1'b0;
   localparam logic CSR_ROWS_IN_USE     = 1'b1;

   localparam logic [VIS_CFG_W-1:0]  VIS_RESET  = 7'd80;
   localparam logic [ROWS_CFG_W-1:0] ROWS_RESET = 6'd25;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [CHAR_W-1:0] data;
   } mem_wr_type;

   typedef struct packed {
      logic [CHAR_W-1:0] read_data;
      logic [ROW_W-1:0]  cursor_row;
      logic [COL_W-1:0]  cursor_column;
   } result_type;

endpackage

`default_nettype wire

// ===== src/tccw_char_ram.sv =====
`default_nettype none

module tccw_char_ram (
   input  wire logic                        clock,
   input  wire tccw_pkg::mem_wr_type        wr,
   input  wire logic                        rd_en,
   input  wire logic [tccw_pkg::ADDR_W-1:0] rd_addr,
   output logic      [tccw_pkg::CHAR_W-1:0] rd_data
);

   logic [tccw_pkg::CHAR_W-1:0] char_mem [tccw_pkg::MAX_ROWS*tccw_pkg::MAX_COLUMNS];

   always_ff @(posedge clock) begin
      if (wr.en) begin
         char_mem[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         rd_data <= char_mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== src/tccw_ctrl.sv =====
`default_nettype none

module tccw_ctrl (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [tccw_pkg::OP_W-1:0]       req_op,
   input  wire logic [tccw_pkg::CHAR_W-1:0]     req_character,
   input  wire logic [tccw_pkg::ROW_W-1:0]      req_read_row,
   input  wire logic [tccw_pkg::COL_W-1:0]      req_read_column,
   input  wire logic [tccw_pkg::VIS_CFG_W-1:0]  vis_eff,
   input  wire logic [tccw_pkg::ROWS_CFG_W-1:0] rows_eff,
   output logic                                 res_valid,
   input  wire logic                            res_take,
   output tccw_pkg::result_type                 res,
   output tccw_pkg::mem_wr_type                 mem_wr,
   output logic                                 rd_en,
   output logic [tccw_pkg::ADDR_W-1:0]          rd_addr,
   input  wire logic [tccw_pkg::CHAR_W-1:0]     rd_data
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_NL,
      S_MOD,
      S_SWEEP,
      S_PUT,
      S_READ,
      S_DONE
   } state_type;

   state_type                           state_ff, state_in;
   logic [tccw_pkg::ROW_W-1:0]          cur_row_ff, cur_row_in;
   logic [tccw_pkg::COL_W-1:0]          cur_col_ff, cur_col_in;
   logic [tccw_pkg::COL_W-1:0]          sweep_col_ff, sweep_col_in;
   logic [tccw_pkg::ROWS_CFG_W-1:0]     mod_ff, mod_in;
   logic [tccw_pkg::CHAR_W-1:0]         char_ff, char_in;
   logic [tccw_pkg::CHAR_W-1:0]         data_ff, data_in;
   logic                                char_pend_ff, char_pend_in;
   logic                                resp_pend_ff, resp_pend_in;
   logic [tccw_pkg::MAX_ROWS-1:0]       row_valid_ff, row_valid_in;

   always_comb begin
      state_in     = state_ff;
      cur_row_in   = cur_row_ff;
      cur_col_in   = cur_col_ff;
      sweep_col_in = sweep_col_ff;
      mod_in       = mod_ff;
      char_in      = char_ff;
      data_in      = data_ff;
      char_pend_in = char_pend_ff;
      resp_pend_in = resp_pend_ff;
      row_valid_in = row_valid_ff;
      mem_wr       = '0;
      rd_en        = 1'b0;
      rd_addr      = {req_read_row, req_read_column};

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               data_in      = '0;
               resp_pend_in = 1'b1;
               unique case (req_op)
                  tccw_pkg::OP_PUT: begin
                     if (req_character == tccw_pkg::NULL_CODE) begin
                        state_in = S_DONE;
                     end else if (req_character == tccw_pkg::NEWLINE_CODE) begin
                        char_pend_in = 1'b0;
                        state_in     = S_NL;
                     end else if (cur_col_ff >= vis_eff) begin
                        char_in      = req_character;
                        char_pend_in = 1'b1;
                        state_in     = S_NL;
                     end else begin
                        mem_wr.en   = 1'b1;
                        mem_wr.addr = {cur_row_ff, cur_col_ff};
                        mem_wr.data = req_character;
                        cur_col_in  = cur_col_ff + 1'b1;
                        state_in    = S_DONE;
                     end
                  end
                  tccw_pkg::OP_CLEAR: begin
                     row_valid_in = '0;
                     cur_row_in   = '0;
                     cur_col_in   = '0;
                     sweep_col_in = '0;
                     char_pend_in = 1'b0;
                     state_in     = S_SWEEP;
                  end
                  tccw_pkg::OP_READ: begin
                     if (({1'b0, req_read_row} < rows_eff) && (req_read_column <= vis_eff)
                         && row_valid_ff[req_read_row]) begin
                        rd_en    = 1'b1;
                        state_in = S_READ;
                     end else begin
                        state_in = S_DONE;
                     end
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_NL: begin
            mem_wr.en   = 1'b1;
            mem_wr.addr = {cur_row_ff, cur_col_ff};
            mem_wr.data = tccw_pkg::NEWLINE_CODE;
            mod_in      = tccw_pkg::ROWS_CFG_W'(cur_row_ff) + 1'b1;
            state_in    = S_MOD;
         end
         S_MOD: begin
            if (mod_ff >= rows_eff) begin
               mod_in = mod_ff - rows_eff;
            end else begin
               cur_row_in   = mod_ff[tccw_pkg::ROW_W-1:0];
               cur_col_in   = '0;
               sweep_col_in = '0;
               state_in     = S_SWEEP;
            end
         end
         S_SWEEP: begin
            mem_wr.en    = 1'b1;
            mem_wr.addr  = {cur_row_ff, sweep_col_ff};
            mem_wr.data  = '0;
            sweep_col_in = sweep_col_ff + 1'b1;
            if (sweep_col_ff == '1) begin
               row_valid_in[cur_row_ff] = 1'b1;
               if (char_pend_ff) begin
                  state_in = S_PUT;
               end else if (resp_pend_ff) begin
                  state_in = S_DONE;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_PUT: begin
            mem_wr.en    = 1'b1;
            mem_wr.addr  = {cur_row_ff, cur_col_ff};
            mem_wr.data  = char_ff;
            cur_col_in   = cur_col_ff + 1'b1;
            char_pend_in = 1'b0;
            state_in     = S_DONE;
         end
         S_READ: begin
            data_in  = rd_data;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (res_take) begin
               resp_pend_in = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      mod_ff  <= mod_in;
      char_ff <= char_in;
      data_ff <= data_in;
      if (reset) begin
         state_ff     <= S_SWEEP;
         cur_row_ff   <= '0;
         cur_col_ff   <= '0;
         sweep_col_ff <= '0;
         char_pend_ff <= 1'b0;
         resp_pend_ff <= 1'b0;
         row_valid_ff <= '0;
      end else begin
         state_ff     <= state_in;
         cur_row_ff   <= cur_row_in;
         cur_col_ff   <= cur_col_in;
         sweep_col_ff <= sweep_col_in;
         char_pend_ff <= char_pend_in;
         resp_pend_ff <= resp_pend_in;
         row_valid_ff <= row_valid_in;
      end
   end

   assign req_ready         = (state_ff == S_IDLE);
   assign res_valid         = (state_ff == S_DONE);
   assign res.read_data     = data_ff;
   assign res.cursor_row    = cur_row_ff;
   assign res.cursor_column = cur_col_ff;

   a_no_read_on_write: assert property (@(posedge clock) disable iff (reset)
      !(mem_wr.en && rd_en))
      else $error("char store read and write in the same cycle");

   a_cursor_row_cleared: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> row_valid_ff[cur_row_ff])
      else $error("cursor row not cleared while idle");

   a_read_data_next: assert property (@(posedge clock) disable iff (reset)
      rd_en |=> (state_ff == S_READ))
      else $error("read issued without capture cycle");

   a_mod_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MOD) |-> (mod_ff <= tccw_pkg::ROWS_CFG_W'(tccw_pkg::MAX_ROWS)))
      else $error("row wrap value out of range");

endmodule

`default_nettype wire

// ===== src/text_console_char_writer_top.sv =====
// a plain put writes its cell and goes to S_DONE; an in-range read captures the cell in S_READ
// newline: S_NL writes the newline code, S_MOD wraps the row by repeated subtract steps,
// S_SWEEP clears the new row (128 cells, one per cycle), a wrapping put then writes in S_PUT
// clear all invalidates every row and sweeps row 0; one transaction at a time goes through
// the char store port; reset: synchronous, active high, then row 0 is swept before req_tready
`default_nettype none

module text_console_char_writer_top (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [31:0]                     req_tdata,  // character, read_row, read_column
   input  wire logic [1:0]                      req_tuser,  // op
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic [31:0]                          rsp_tdata,  // read_data, cursor_row, cursor_column
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic                            csr_index,
   input  wire logic [tccw_pkg::CSR_DATA_W-1:0] csr_data
);

   logic [tccw_pkg::VIS_CFG_W-1:0]  vis_ff;
   logic [tccw_pkg::ROWS_CFG_W-1:0] rows_ff;
   logic [tccw_pkg::VIS_CFG_W-1:0]  vis_eff;
   logic [tccw_pkg::ROWS_CFG_W-1:0] rows_eff;

   logic                 rsp_valid_ff;
   tccw_pkg::result_type rsp_ff;
   tccw_pkg::result_type res;
   logic                 res_valid;
   logic                 res_take;

   tccw_pkg::mem_wr_type              mem_wr;
   logic                              rd_en;
   logic [tccw_pkg::ADDR_W-1:0]       rd_addr;
   logic [tccw_pkg::CHAR_W-1:0]       rd_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         vis_ff  <= tccw_pkg::VIS_RESET;
         rows_ff <= tccw_pkg::ROWS_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            tccw_pkg::CSR_VISIBLE_COLUMNS: vis_ff  <= csr_data;
            tccw_pkg::CSR_ROWS_IN_USE:     rows_ff <= csr_data[tccw_pkg::ROWS_CFG_W-1:0];
            default: ;
         endcase
      end
   end

   // zero means one; rows limited to the ring size
   always_comb begin
      vis_eff = (vis_ff == '0) ? tccw_pkg::VIS_CFG_W'(1) : vis_ff;
      if (rows_ff == '0) begin
         rows_eff = tccw_pkg::ROWS_CFG_W'(1);
      end else if (rows_ff > tccw_pkg::ROWS_CFG_W'(tccw_pkg::MAX_ROWS)) begin
         rows_eff = tccw_pkg::ROWS_CFG_W'(tccw_pkg::MAX_ROWS);
      end else begin
         rows_eff = rows_ff;
      end
   end

   assign res_take = res_valid && (!rsp_valid_ff || rsp_tready);

   always_ff @(posedge clock) begin
      if (res_take) begin
         rsp_ff <= res;
      end
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_take) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0, rsp_ff.cursor_column, rsp_ff.cursor_row, rsp_ff.read_data};

   tccw_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_tvalid),
      .req_ready       (req_tready),
      .req_op          (req_tuser),
      .req_character   (req_tdata[15:0]),
      .req_read_row    (req_tdata[20:16]),
      .req_read_column (req_tdata[27:21]),
      .vis_eff         (vis_eff),
      .rows_eff        (rows_eff),
      .res_valid       (res_valid),
      .res_take        (res_take),
      .res             (res),
      .mem_wr          (mem_wr),
      .rd_en           (rd_en),
      .rd_addr         (rd_addr),
      .rd_data         (rd_data)
   );

   tccw_char_ram u_char_ram (
      .clock   (clock),
      .wr      (mem_wr),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

endmodule

`default_nettype wire

// ===== tb/text_console_char_writer_checker.sv =====
`default_nettype none

module text_console_char_writer_checker
   import tccw_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   input  wire logic                  req_tready,
   input  wire logic [31:0]           req_tdata,  // character, read_row, read_column
   input  wire logic [1:0]            req_tuser,  // op
   input  wire logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   input  wire logic [31:0]           rsp_tdata,  // read_data, cursor_row, cursor_column
   input  wire logic                  csr_valid,
   input  wire logic                  csr_ready,
   input  wire logic                  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data,
   output int                         mismatches,
   output int                         replies_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [CHAR_W-1:0] data;
      logic [ROW_W-1:0]  row;
      logic [COL_W-1:0]  col;
   } console_reply_type;

   logic [CHAR_W-1:0]     cell_ring [MAX_ROWS][MAX_COLUMNS];
   int                    row_pos;
   int                    col_pos;
   logic [VIS_CFG_W-1:0]  visible_cfg;
   logic [ROWS_CFG_W-1:0] rows_cfg;
   console_reply_type     expected_replies [$];
   int                    reply_index;

   initial begin
      mismatches      = 0;
      replies_pending = 0;
      reply_index     = 0;
   end

   function automatic int usable_columns();
      int v;
      v = int'(visible_cfg);
      if (v == 0) v = 1;
      if (v > MAX_COLUMNS - 1) v = MAX_COLUMNS - 1;
      return v;
   endfunction

   function automatic int ring_rows();
      int r;
      r = int'(rows_cfg);
      if (r == 0) r = 1;
      if (r > MAX_ROWS) r = MAX_ROWS;
      return r;
   endfunction

   function automatic void wipe_row(int r);
      for (int c = 0; c < MAX_COLUMNS; c++) cell_ring[r][c] = '0;
   endfunction

   function automatic void wipe_ring();
      for (int r = 0; r < MAX_ROWS; r++) wipe_row(r);
   endfunction

   function automatic void end_of_line();
      if (row_pos < MAX_ROWS && col_pos < MAX_COLUMNS)
         cell_ring[row_pos][col_pos] = NEWLINE_CODE;
      row_pos = (row_pos + 1) % ring_rows();
      col_pos = 0;
      wipe_row(row_pos);
   endfunction

   function automatic console_reply_type console_step(logic [OP_W-1:0] op,
                                                      logic [CHAR_W-1:0] ch,
                                                      logic [ROW_W-1:0] rr,
                                                      logic [COL_W-1:0] rc);
      console_reply_type rep;
      rep.data = '0;
      case (op)
         OP_PUT: begin
            if (ch == NEWLINE_CODE) begin
               end_of_line();
            end else if (ch != NULL_CODE) begin
               // cursor on or past the line-end slot wraps first
               if (col_pos >= usable_columns()) end_of_line();
               if (row_pos < MAX_ROWS && col_pos < MAX_COLUMNS)
                  cell_ring[row_pos][col_pos] = ch;
               col_pos++;
            end
         end
         OP_CLEAR: begin
            wipe_ring();
            row_pos = 0;
            col_pos = 0;
         end
         OP_READ: begin
            if (int'(rr) < ring_rows() && int'(rc) <= usable_columns())
               rep.data = cell_ring[rr][rc];
         end
         default: ;
      endcase
      rep.row = row_pos[ROW_W-1:0];
      rep.col = col_pos[COL_W-1:0];
      return rep;
   endfunction

   always @(posedge clock) begin : watch
      console_reply_type got;
      console_reply_type want;
      if (reset) begin
         wipe_ring();
         row_pos     = 0;
         col_pos     = 0;
         visible_cfg = VIS_RESET;
         rows_cfg    = ROWS_RESET;
         expected_replies.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.data = rsp_tdata[15:0];
            got.row  = rsp_tdata[20:16];
            got.col  = rsp_tdata[27:21];
            if (expected_replies.size() == 0) begin
               if (mismatches < 10)
                  $display("reply %0d with none expected: data %h row %0d col %0d",
                           reply_index, got.data, got.row, got.col);
               mismatches++;
            end else begin
               want = expected_replies.pop_front();
               if (got.data != want.data || got.row != want.row || got.col != want.col) begin
                  if (mismatches < 10) begin
                     $display("reply %0d: expected data %h row %0d col %0d",
                              reply_index, want.data, want.row, want.col);
                     $display("reply %0d: got      data %h row %0d col %0d",
                              reply_index, got.data, got.row, got.col);
                  end
                  mismatches++;
               end
            end
            reply_index++;
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_VISIBLE_COLUMNS) visible_cfg = csr_data[VIS_CFG_W-1:0];
            else rows_cfg = csr_data[ROWS_CFG_W-1:0];
         end
         if (req_tvalid && req_tready)
            expected_replies.push_back(console_step(req_tuser, req_tdata[15:0],
                                                    req_tdata[20:16], req_tdata[27:21]));
      end
      replies_pending <= expected_replies.size();
   end

endmodule

`default_nettype wire

// ===== tb/text_console_char_writer_top_test.sv =====
`default_nettype none

module text_console_char_writer_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   import tccw_pkg::*;

   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int SETTLE_CYCLES = 200;
   localparam int HOLD_CYCLES   = 500;
   localparam int PHASES        = 12;
   localparam int PHASE_ITEMS   = 106;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [31:0]           req_tdata;
   logic [1:0]            req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [31:0]           rsp_tdata;
   logic                  csr_valid;
   logic                  csr_ready;
   logic                  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;
   int                    mismatches;
   int                    replies_pending;

   bit quiet;
   bit long_hold;
   bit long_hold_done;
   int vis_now;
   int rows_now;

   text_console_char_writer_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   text_console_char_writer_checker checker_i (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .mismatches      (mismatches),
      .replies_pending (replies_pending)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #4000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   // receiver side
   initial begin
      int hold_count;
      int low;
      long_hold_done = 1'b0;
      rsp_tready     = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (long_hold && !long_hold_done) begin
            rsp_tready <= 1'b0;
            hold_count = 0;
            while (hold_count < HOLD_CYCLES) begin
               @(posedge clock);
               hold_count++;
            end
            long_hold_done = 1'b1;
         end else begin
            low = idle_len();
            if (low > 0) begin
               rsp_tready <= 1'b0;
               repeat (low) @(posedge clock);
            end
            rsp_tready <= 1'b1;
            repeat (1 + $urandom_range(0, 6)) @(posedge clock);
         end
      end
   end

   task automatic send_item(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch,
                            input logic [ROW_W-1:0] rr, input logic [COL_W-1:0] rc);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {4'b0, rc, rr, ch};
      do @(posedge clock); while (!req_tready);
      gap = idle_len();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain_replies();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (replies_pending != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_console(input int vis, input int rows);
      drain_replies();
      repeat (SETTLE_CYCLES) @(posedge clock);
      write_reg(CSR_VISIBLE_COLUMNS, vis[CSR_DATA_W-1:0]);
      write_reg(CSR_ROWS_IN_USE, rows[CSR_DATA_W-1:0]);
      vis_now  = vis & 127;
      rows_now = rows & 63;
   endtask

   task automatic random_item();
      int r;
      int s;
      int vis_eff;
      int rows_eff;
      logic [OP_W-1:0]   op;
      logic [CHAR_W-1:0] ch;
      logic [ROW_W-1:0]  rr;
      logic [COL_W-1:0]  rc;
      vis_eff  = (vis_now == 0) ? 1 : vis_now;
      rows_eff = (rows_now == 0) ? 1 : ((rows_now > MAX_ROWS) ? MAX_ROWS : rows_now);
      ch = CHAR_W'($urandom);
      rr = ROW_W'($urandom);
      rc = COL_W'($urandom);
      r  = $urandom_range(0, 99);
      if (r < 72) begin
         op = OP_PUT;
         s  = $urandom_range(0, 99);
         if (s < 10) ch = NEWLINE_CODE;
         else if (s < 14) ch = NULL_CODE;
         else if (s >= 30) ch = CHAR_W'($urandom_range(8'h20, 8'h7e));
      end else if (r < 96) begin
         op = OP_READ;
         s  = $urandom_range(0, 99);
         // mostly inside the written area, near the top rows
         if (s < 40) begin
            rr = ROW_W'($urandom_range(0, (rows_eff < 4) ? rows_eff - 1 : 3));
            rc = COL_W'($urandom_range(0, vis_eff));
         end else if (s < 75) begin
            rr = ROW_W'($urandom_range(0, rows_eff - 1));
            rc = COL_W'($urandom_range(0, vis_eff));
         end
      end else if (r < 98) begin
         op = OP_CLEAR;
      end else begin
         op = OP_UNUSED;
      end
      send_item(op, ch, rr, rc);
   endtask

   initial begin
      int vis_list  [PHASES];
      int rows_list [PHASES];
      vis_list  = '{1, 127, 0, 5, 127, 2, 40, 10, 80, 0, 0, 0};
      rows_list = '{1, 32, 0, 3, 63, 2, 68, 33, 25, 0, 0, 0};
      quiet      = 1'b0;
      long_hold  = 1'b0;
      vis_now    = int'(VIS_RESET);
      rows_now   = int'(ROWS_RESET);
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= '0;
      csr_valid  <= 1'b0;
      csr_index  <= 1'b0;
      csr_data   <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset configuration
      send_item(OP_READ, '0, 5'd0, 7'd0);
      send_item(OP_PUT, 16'h0041, '0, '0);
      send_item(OP_PUT, NULL_CODE, '0, '0);
      send_item(OP_PUT, 16'hffff, '0, '0);
      send_item(OP_READ, '0, 5'd0, 7'd0);
      send_item(OP_READ, '0, 5'd0, 7'd1);
      send_item(OP_PUT, NEWLINE_CODE, '0, '0);
      send_item(OP_READ, '0, 5'd0, 7'd2);
      send_item(OP_READ, '0, 5'd1, 7'd0);
      send_item(OP_READ, '0, 5'd24, 7'd80);
      send_item(OP_READ, '0, 5'd25, 7'd0);
      send_item(OP_READ, '0, 5'd0, 7'd81);
      send_item(OP_READ, '1, 5'd31, 7'd127);
      send_item(OP_UNUSED, '1, '1, '1);
      send_item(OP_PUT, 16'h007e, '0, '0);
      send_item(OP_CLEAR, '0, '0, '0);
      send_item(OP_READ, '0, 5'd0, 7'd0);

      for (int p = 0; p < PHASES; p++) begin
         if (p >= 9) begin
            vis_list[p]  = $urandom_range(0, 127);
            rows_list[p] = $urandom_range(0, 99) < 80 ? $urandom_range(1, 40)
                                                      : $urandom_range(0, 127);
         end
         set_console(vis_list[p], rows_list[p]);
         quiet = (p == 5);
         if (p == 3) long_hold = 1'b1;
         if (p == 0) begin
            // one column, one row: a put with the cursor past the column wraps onto the same row
            send_item(OP_PUT, 16'h0078, '0, '0);
            send_item(OP_PUT, 16'h0079, '0, '0);
            send_item(OP_READ, '0, 5'd0, 7'd0);
            send_item(OP_READ, '0, 5'd0, 7'd1);
            send_item(OP_PUT, NEWLINE_CODE, '0, '0);
            send_item(OP_PUT, 16'h007a, '0, '0);
            send_item(OP_READ, '0, 5'd0, 7'd0);
         end
         for (int i = 0; i < PHASE_ITEMS; i++) random_item();
      end

      quiet = 1'b0;
      drain_replies();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0 && replies_pending == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

`default_nettype wire
